// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthand used by the checker file of this block.
// Each macro clocks on the given clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MFP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mfp_pkg.sv =====
// Types, constants and the message layout table of the market-feed field parser.
// Depends on nothing; used by every module of the block.
package mfp_pkg;

  localparam int HEADER_BYTES_DEF = 2;
  localparam int MAX_FIELDS       = 17;
  localparam int HCNT_W           = 2;
  localparam int FNUM_W           = 5;
  localparam int FLEN_W           = 4;
  localparam int VALUE_W          = 64;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Message type codes.
  localparam logic [7:0] MT_S = 8'h53;
  localparam logic [7:0] MT_R = 8'h52;
  localparam logic [7:0] MT_H = 8'h48;
  localparam logic [7:0] MT_Y = 8'h59;
  localparam logic [7:0] MT_L = 8'h4C;
  localparam logic [7:0] MT_V = 8'h56;
  localparam logic [7:0] MT_W = 8'h57;
  localparam logic [7:0] MT_K = 8'h4B;
  localparam logic [7:0] MT_J = 8'h4A;
  localparam logic [7:0] MT_h = 8'h68;
  localparam logic [7:0] MT_A = 8'h41;
  localparam logic [7:0] MT_F = 8'h46;
  localparam logic [7:0] MT_E = 8'h45;
  localparam logic [7:0] MT_C = 8'h43;
  localparam logic [7:0] MT_X = 8'h58;
  localparam logic [7:0] MT_D = 8'h44;
  localparam logic [7:0] MT_U = 8'h55;
  localparam logic [7:0] MT_P = 8'h50;
  localparam logic [7:0] MT_Q = 8'h51;
  localparam logic [7:0] MT_B = 8'h42;
  localparam logic [7:0] MT_I = 8'h49;

  typedef struct packed {
    logic                                 known;
    logic [FNUM_W-1:0]                    nfields;
    logic [0:MAX_FIELDS-1][FLEN_W-1:0]    lens;
  } layout_t;

  typedef struct packed {
    logic [7:0]         message_type;
    logic [FNUM_W-1:0]  field_index;
    logic [VALUE_W-1:0] field_value;
    logic [FLEN_W-1:0]  field_length;
    logic               last_field;
    logic               parse_error;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

  // Field count and byte widths of each known message type.
  function automatic layout_t lookup_layout(input logic [7:0] code);
    layout_t l;
    l.known   = 1'b1;
    l.nfields = '0;
    l.lens    = '0;
    unique case (code)
      MT_S: begin l.nfields = 5'd4;  l.lens = {4'd2,4'd2,4'd6,4'd1,{13{4'd0}}}; end
      MT_R: begin
        l.nfields = 5'd17;
        l.lens = {4'd2,4'd2,4'd6,4'd8,4'd1,4'd1,4'd4,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,
                  4'd1,4'd1,4'd4,4'd1};
      end
      MT_H: begin l.nfields = 5'd7;  l.lens = {4'd2,4'd2,4'd6,4'd8,4'd1,4'd1,4'd4,{10{4'd0}}}; end
      MT_Y: begin l.nfields = 5'd5;  l.lens = {4'd2,4'd2,4'd6,4'd8,4'd1,{12{4'd0}}}; end
      MT_L: begin
        l.nfields = 5'd8;
        l.lens = {4'd2,4'd2,4'd6,4'd4,4'd8,4'd1,4'd1,4'd1,{9{4'd0}}};
      end
      MT_V: begin l.nfields = 5'd6;  l.lens = {4'd2,4'd2,4'd6,4'd8,4'd8,4'd8,{11{4'd0}}}; end
      MT_W: begin l.nfields = 5'd4;  l.lens = {4'd2,4'd2,4'd6,4'd1,{13{4'd0}}}; end
      MT_K: begin l.nfields = 5'd7;  l.lens = {4'd2,4'd2,4'd6,4'd8,4'd4,4'd1,4'd4,{10{4'd0}}}; end
      // The collar extension of this type ends in a four-byte field.
      MT_J: begin
        l.nfields = 5'd8;
        l.lens = {4'd2,4'd2,4'd6,4'd8,4'd4,4'd4,4'd4,4'd4,{9{4'd0}}};
      end
      MT_h: begin l.nfields = 5'd6;  l.lens = {4'd2,4'd2,4'd6,4'd8,4'd1,4'd1,{11{4'd0}}}; end
      MT_A: begin
        l.nfields = 5'd8;
        l.lens = {4'd2,4'd2,4'd6,4'd8,4'd1,4'd4,4'd8,4'd4,{9{4'd0}}};
      end
      MT_F: begin
        l.nfields = 5'd9;
        l.lens = {4'd2,4'd2,4'd6,4'd8,4'd1,4'd4,4'd8,4'd4,4'd4,{8{4'd0}}};
      end
      MT_E: begin l.nfields = 5'd6;  l.lens = {4'd2,4'd2,4'd6,4'd8,4'd4,4'd8,{11{4'd0}}}; end
      MT_C: begin
        l.nfields = 5'd8;
        l.lens = {4'd2,4'd2,4'd6,4'd8,4'd4,4'd8,4'd1,4'd4,{9{4'd0}}};
      end
      MT_X: begin l.nfields = 5'd5;  l.lens = {4'd2,4'd2,4'd6,4'd8,4'd4,{12{4'd0}}}; end
      MT_D: begin l.nfields = 5'd4;  l.lens = {4'd2,4'd2,4'd6,4'd8,{13{4'd0}}}; end
      MT_U: begin l.nfields = 5'd7;  l.lens = {4'd2,4'd2,4'd6,4'd8,4'd8,4'd4,4'd4,{10{4'd0}}}; end
      MT_P: begin
        l.nfields = 5'd9;
        l.lens = {4'd2,4'd2,4'd6,4'd8,4'd1,4'd4,4'd8,4'd4,4'd8,{8{4'd0}}};
      end
      MT_Q: begin
        l.nfields = 5'd8;
        l.lens = {4'd2,4'd2,4'd6,4'd8,4'd8,4'd4,4'd8,4'd1,{9{4'd0}}};
      end
      MT_B: begin l.nfields = 5'd4;  l.lens = {4'd2,4'd2,4'd6,4'd8,{13{4'd0}}}; end
      MT_I: begin
        l.nfields = 5'd12;
        l.lens = {4'd2,4'd2,4'd6,4'd8,4'd8,4'd1,4'd8,4'd4,4'd4,4'd4,4'd1,4'd1,{5{4'd0}}};
      end
      default: l.known = 1'b0;
    endcase
    return l;
  endfunction

endpackage

// ===== hw/rtl/mfp_core.sv =====
// Framing state and field assembly of the market-feed field parser.
// Uses mfp_pkg for the layout table and the result types.
module mfp_core #(
  parameter int HEADER_BYTES = mfp_pkg::HEADER_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data_byte,
  output mfp_pkg::push_t push
);
  import mfp_pkg::*;

  localparam phase_t START_PHASE = (HEADER_BYTES > 0) ? PH_HEADER : PH_TYPE;

  phase_t             phase, phase_next;
  logic [HCNT_W-1:0]  header_count, header_count_next;
  logic [7:0]         current_type, current_type_next;
  logic [FNUM_W-1:0]  field_number, field_number_next;
  logic [FLEN_W-1:0]  field_byte_count, field_byte_count_next;
  logic [VALUE_W-1:0] value_accumulator, value_accumulator_next;

  layout_t            in_lay, cur_lay;
  logic [FLEN_W-1:0]  flen;
  logic [FLEN_W-1:0]  cnt_inc;
  logic [VALUE_W-1:0] acc_shift;
  logic               fn_ok, field_done, is_last;
  logic [2:0]         hdr_inc;

  assign in_lay    = lookup_layout(data_byte);
  assign cur_lay   = lookup_layout(current_type);
  assign fn_ok     = cur_lay.known && (field_number < cur_lay.nfields);
  assign flen      = (field_number < FNUM_W'(MAX_FIELDS)) ? cur_lay.lens[field_number] : '0;
  assign cnt_inc   = field_byte_count + FLEN_W'(1);
  assign acc_shift = {value_accumulator[VALUE_W-9:0], data_byte};
  assign field_done = !(cnt_inc < flen);
  assign is_last   = ({1'b0, field_number} + 6'd1) >= {1'b0, cur_lay.nfields};
  assign hdr_inc   = {1'b0, header_count} + 3'd1;

  // Next state.
  always_comb begin
    phase_next             = phase;
    header_count_next      = header_count;
    current_type_next      = current_type;
    field_number_next      = field_number;
    field_byte_count_next  = field_byte_count;
    value_accumulator_next = value_accumulator;
    unique case (phase)
      PH_TYPE: begin
        if (!in_lay.known) begin
          phase_next = START_PHASE;
          header_count_next = '0;
        end else begin
          current_type_next = data_byte;
          phase_next = PH_PAYLOAD;
        end
        field_number_next      = '0;
        field_byte_count_next  = '0;
        value_accumulator_next = '0;
      end
      PH_PAYLOAD: begin
        if (!fn_ok || (field_done && is_last)) begin
          phase_next             = START_PHASE;
          header_count_next      = '0;
          field_number_next      = '0;
          field_byte_count_next  = '0;
          value_accumulator_next = '0;
        end else if (field_done) begin
          field_number_next      = field_number + FNUM_W'(1);
          field_byte_count_next  = '0;
          value_accumulator_next = '0;
        end else begin
          field_byte_count_next  = cnt_inc;
          value_accumulator_next = acc_shift;
        end
      end
      default: begin
        // The spare phase code behaves as the header phase.
        if (hdr_inc >= 3'(HEADER_BYTES)) begin
          header_count_next = '0;
          phase_next = PH_TYPE;
        end else begin
          header_count_next = hdr_inc[HCNT_W-1:0];
          phase_next = PH_HEADER;
        end
      end
    endcase
  end

  // Result of the byte being transferred.
  always_comb begin
    push.valid = 1'b0;
    push.res.message_type = current_type;
    push.res.field_index  = field_number;
    push.res.field_value  = acc_shift;
    push.res.field_length = flen;
    push.res.last_field   = is_last;
    push.res.parse_error  = 1'b0;
    unique case (phase)
      PH_TYPE: begin
        push.valid = take && !in_lay.known;
        push.res.message_type = data_byte;
        push.res.field_index  = '0;
        push.res.field_value  = '0;
        push.res.field_length = '0;
        push.res.last_field   = 1'b1;
        push.res.parse_error  = 1'b1;
      end
      PH_PAYLOAD: push.valid = take && fn_ok && field_done;
      default:    push.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= START_PHASE;
      header_count      <= '0;
      current_type      <= '0;
      field_number      <= '0;
      field_byte_count  <= '0;
      value_accumulator <= '0;
    end else if (take) begin
      phase             <= phase_next;
      header_count      <= header_count_next;
      current_type      <= current_type_next;
      field_number      <= field_number_next;
      field_byte_count  <= field_byte_count_next;
      value_accumulator <= value_accumulator_next;
    end
  end

endmodule

// ===== hw/rtl/mfp_out_buf.sv =====
// Two-entry result buffer that decouples the parser from the receiver.
// Uses mfp_pkg for the result types.
module mfp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  mfp_pkg::push_t   push,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output mfp_pkg::result_t head
);
  import mfp_pkg::*;

  result_t    entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic       pop;

  assign space     = !count[1];
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign head      = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push.valid && !pop) begin
      count_next = count + 2'd1;
    end else if (!push.valid && pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

// ===== hw/rtl/market_feed_message_field_parser.sv =====
// Market-feed message field parser, top level. Uses mfp_pkg, mfp_core and mfp_out_buf.
//
// Input channel: one stream byte per transfer on data_byte, in_valid / in_ready.
// Each message is HEADER_BYTES length bytes (ignored), a type byte and a fixed
// payload whose layout comes from the type. Output channel: one result per
// completed field, with out_valid / out_ready; unknown types give one error
// result and framing restarts at the header.
// The result of a byte that completes a field is written to the result buffer at
// that byte's transfer. Throughput: one byte per cycle while in_ready is high;
// the layout lookup, byte shift and length compare fit between the state
// registers and the result buffer.
// Reset clears framing to the start of a header and empties the buffer.
// When the receiver stalls, the two-entry result buffer keeps taking bytes;
// in_ready drops only while both entries hold untaken results.
module market_feed_message_field_parser #(
  parameter int HEADER_BYTES = mfp_pkg::HEADER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   message_type,
  output logic [mfp_pkg::FNUM_W-1:0]   field_index,
  output logic [mfp_pkg::VALUE_W-1:0]  field_value,
  output logic [mfp_pkg::FLEN_W-1:0]   field_length,
  output logic                         last_field,
  output logic                         parse_error
);
  import mfp_pkg::*;

  push_t   push;
  result_t head;
  logic    take;

  assign take = in_valid && in_ready;

  mfp_core #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .push      (push)
  );

  mfp_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign message_type = head.message_type;
  assign field_index  = head.field_index;
  assign field_value  = head.field_value;
  assign field_length = head.field_length;
  assign last_field   = head.last_field;
  assign parse_error  = head.parse_error;

endmodule

// ===== hw/rtl/mfp_checker.sv =====
// Port-level checks of the market-feed field parser and their binding to the top level.
// Uses assert_macros.svh and mfp_pkg.
`include "assert_macros.svh"

module mfp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [7:0]                   message_type,
  input logic [mfp_pkg::FNUM_W-1:0]   field_index,
  input logic [mfp_pkg::VALUE_W-1:0]  field_value,
  input logic [mfp_pkg::FLEN_W-1:0]   field_length,
  input logic                         last_field,
  input logic                         parse_error
);
  import mfp_pkg::*;

  // A stalled result stays in place until its transfer.
  `MFP_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(message_type) && $stable(field_index) && $stable(field_value) && $stable(field_length) && $stable(last_field) && $stable(parse_error), "stalled result changed")

  // An error result is a lone last field with no bytes.
  `MFP_ASSERT_IMPL(a_err_shape, clk, rst, out_valid && parse_error, field_length == '0 && field_index == '0 && field_value == '0 && last_field, "malformed error result")

  // A normal field carries one to eight bytes.
  `MFP_ASSERT_IMPL(a_len_range, clk, rst, out_valid && !parse_error, field_length != '0 && field_length <= FLEN_W'(8), "field length out of range")

  // Input is held back only while results are waiting.
  `MFP_ASSERT_IMPL(a_backpressure, clk, rst, !in_ready, out_valid, "input stalled with no pending result")

endmodule

bind market_feed_message_field_parser mfp_checker u_mfp_checker (.*);
